// ===== sv/ipr_pkg.sv =====
// Shared types, widths and constants for the quaternion to pitch/roll block.
// Holds the arctangent table used by the CORDIC stages.
// No dependencies.
package ipr_pkg;

  localparam int QW = 16;
  localparam int TS_W = 63;
  localparam int ANG_W = 14;
  localparam int LIM_W = 13;
  localparam int CORDIC_STAGES_DEF = 14;
  localparam logic [LIM_W-1:0] LIMIT_RST = 13'd4915;

  // Saturated sine is within +-2^28, so the square root input fits 57 bits
  // and the root fits 29 bits.
  localparam int SQ_W = 29;
  localparam int SQ_IN_W = 2 * SQ_W - 1;

  // CORDIC datapath: operands reach 2^32, grow by the CORDIC gain.
  localparam int CW = 37;
  localparam int ZW = 25;
  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 25'sd1647099;

  typedef struct packed {
    logic [TS_W-1:0]        ts;
    logic signed [QW-1:0]   hw;
    logic signed [QW-1:0]   hx;
    logic signed [QW-1:0]   hy;
    logic signed [QW-1:0]   hz;
  } side_t;

  // Negation that saturates the most negative code.
  function automatic logic signed [QW-1:0] neg_sat(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] r;
    if (v == {1'b1, {(QW-1){1'b0}}}) begin
      r = {1'b0, {(QW-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // atan(2^-i) in Q20 radians, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 25'sd823550;
      5'd1:  r = 25'sd486170;
      5'd2:  r = 25'sd256879;
      5'd3:  r = 25'sd130396;
      5'd4:  r = 25'sd65451;
      5'd5:  r = 25'sd32757;
      5'd6:  r = 25'sd16383;
      5'd7:  r = 25'sd8192;
      5'd8:  r = 25'sd4096;
      5'd9:  r = 25'sd2048;
      5'd10: r = 25'sd1024;
      5'd11: r = 25'sd512;
      5'd12: r = 25'sd256;
      5'd13: r = 25'sd128;
      5'd14: r = 25'sd64;
      5'd15: r = 25'sd32;
      5'd16: r = 25'sd16;
      5'd17: r = 25'sd8;
      5'd18: r = 25'sd4;
      5'd19: r = 25'sd2;
      5'd20: r = 25'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ipr_if.sv =====
// Valid/ready channel interfaces for the quaternion input and the result output.
// Depends on ipr_pkg for field widths.
interface ipr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ipr_pkg::QW-1:0]      quat_w;
  logic signed [ipr_pkg::QW-1:0]      quat_x;
  logic signed [ipr_pkg::QW-1:0]      quat_y;
  logic signed [ipr_pkg::QW-1:0]      quat_z;
  logic [ipr_pkg::TS_W-1:0]           timestamp_us;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, timestamp_us, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, timestamp_us, output ready);
endinterface

interface ipr_out_if;
  logic                               valid;
  logic                               ready;
  logic [ipr_pkg::TS_W-1:0]           timestamp_out;
  logic signed [ipr_pkg::QW-1:0]      head_w;
  logic signed [ipr_pkg::QW-1:0]      head_x;
  logic signed [ipr_pkg::QW-1:0]      head_y;
  logic signed [ipr_pkg::QW-1:0]      head_z;
  logic signed [ipr_pkg::ANG_W-1:0]   pitch_cmd;
  logic signed [ipr_pkg::ANG_W-1:0]   roll_cmd;

  modport source (output valid, timestamp_out, head_w, head_x, head_y, head_z,
                  pitch_cmd, roll_cmd, input ready);
  modport sink (input valid, timestamp_out, head_w, head_x, head_y, head_z,
                pitch_cmd, roll_cmd, output ready);
endinterface

// ===== sv/ipr_isqrt.sv =====
// Pipelined floor square root, one result bit per register stage.
// Depends on ipr_pkg for widths.
module ipr_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ipr_pkg::SQ_IN_W-1:0]   n_in,
  output logic [ipr_pkg::SQ_W-1:0]      root_out
);

  localparam int OW = ipr_pkg::SQ_W;
  localparam int IW = ipr_pkg::SQ_IN_W;

  logic [IW-1:0] rem_r  [OW];
  logic [OW-1:0] root_r [OW];

  for (genvar j = 0; j < OW; j++) begin : g_stage
    localparam int K = OW - 1 - j;
    logic [IW-1:0] rem_p;
    logic [OW-1:0] root_p;
    logic [IW:0]   trial;
    logic [IW-1:0] rem_nxt;
    logic [OW-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign rem_p  = n_in;
      assign root_p = '0;
    end else begin : g_next
      assign rem_p  = rem_r[j-1];
      assign root_p = root_r[j-1];
    end

    // Bits found so far lie above K, so (r + 2^K)^2 - r^2 is r*2^(K+1) | 2^(2K).
    always_comb begin
      trial = ({{(IW+1-OW){1'b0}}, root_p} << (K + 1)) | ((IW+1)'(1) << (2 * K));
      if ({1'b0, rem_p} >= trial) begin
        rem_nxt  = rem_p - trial[IW-1:0];
        root_nxt = root_p | (OW'(1) << K);
      end else begin
        rem_nxt  = rem_p;
        root_nxt = root_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
      end
    end
  end

  assign root_out = root_r[OW-1];

endmodule

// ===== sv/ipr_cordic.sv =====
// Unrolled vectoring CORDIC: atan2(y, x) in Q20 radians, one register per rotation.
// Depends on ipr_pkg for widths and the arctangent table.
module ipr_cordic #(
  parameter int STAGES = ipr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [ipr_pkg::CW-1:0]   x_in,
  input  logic signed [ipr_pkg::CW-1:0]   y_in,
  output logic signed [ipr_pkg::ZW-1:0]   z_out
);

  localparam int W  = ipr_pkg::CW;
  localparam int ZW = ipr_pkg::ZW;

  logic signed [W-1:0]  x_r  [STAGES+1];
  logic signed [W-1:0]  y_r  [STAGES+1];
  logic signed [ZW-1:0] z_r  [STAGES+1];
  logic                 zf_r [STAGES+1];

  // A vector in the left half plane is first turned by a quarter turn.
  always_ff @(posedge clk) begin
    if (en) begin
      zf_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r[0] <= y_in;
          y_r[0] <= -x_in;
          z_r[0] <= ipr_pkg::HALF_PI_Q20;
        end else begin
          x_r[0] <= -y_in;
          y_r[0] <= x_in;
          z_r[0] <= -ipr_pkg::HALF_PI_Q20;
        end
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[i+1] <= zf_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ipr_pkg::atan_q20(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ipr_pkg::atan_q20(5'(i));
        end
      end
    end
  end

  assign z_out = zf_r[STAGES] ? '0 : z_r[STAGES];

endmodule

// ===== sv/imu_quat_to_clamped_pitch_roll.sv =====
// Stages from accepted input to result:
// five product/setup stages, 29 square root stages, CORDIC_STAGES + 1 CORDIC stages,
// one rounding and one clamp stage. Throughput: one transaction per cycle.
// The whole pipeline advances together; it holds while a result waits unaccepted.
// Reset (rst_n, synchronous, active low) clears all valid bits and sets the limit to 1.2 rad.
module imu_quat_to_clamped_pitch_roll #(
  parameter int CORDIC_STAGES = ipr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ipr_in_if.sink                       in_ch,
  ipr_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [ipr_pkg::LIM_W-1:0]    cfg_wdata
);

  localparam int SQ_W = ipr_pkg::SQ_W;
  localparam int SQ_IN_W = ipr_pkg::SQ_IN_W;
  localparam int CW   = ipr_pkg::CW;
  localparam int ZW   = ipr_pkg::ZW;
  localparam int ANG_W = ipr_pkg::ANG_W;
  localparam int C_STAGE = 5 + SQ_W;
  localparam int LAT  = C_STAGE + CORDIC_STAGES + 3;
  localparam int RW   = ZW - 7;

  logic                      adv;
  logic                      vld_r  [LAT];
  ipr_pkg::side_t            side_r [LAT];
  logic [ipr_pkg::LIM_W-1:0] lim_r;

  logic signed [31:0] wy_r, zx_r, wx_r, yz_r, xx_r, yy_r;
  logic signed [32:0] diff_r;
  // The saturated sine reaches +-2^28, which needs one bit above the root width.
  logic signed [SQ_W:0] s_d_r [SQ_W+3];
  logic signed [33:0] num_d_r [SQ_W+4];
  logic signed [33:0] den_d_r [SQ_W+4];
  logic [SQ_W-1:0]    mag_r;
  logic [SQ_IN_W-1:0] sq_r, n_r;
  logic [SQ_W-1:0]    root;

  logic signed [32:0] sum_a, sum_b, absd;
  logic signed [SQ_W:0] s_nxt;
  logic [SQ_W-1:0]    mag_nxt;

  logic signed [ZW-1:0] zp, zr;
  logic signed [RW-1:0] pr_r, rr_r;
  logic signed [RW-1:0] lim_s, pc, rc;
  logic signed [ANG_W-1:0] pitch_r, roll_r;

  assign adv         = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= ipr_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      lim_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Pass-through fields travel beside the arithmetic.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].ts <= in_ch.timestamp_us;
      side_r[0].hw <= in_ch.quat_w;
      side_r[0].hx <= ipr_pkg::neg_sat(in_ch.quat_x);
      side_r[0].hy <= in_ch.quat_y;
      side_r[0].hz <= ipr_pkg::neg_sat(in_ch.quat_z);
      for (int i = 1; i < LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  // Stage 1: component products, exact Q4.28.
  always_ff @(posedge clk) begin
    if (adv) begin
      wy_r <= in_ch.quat_w * in_ch.quat_y;
      zx_r <= in_ch.quat_z * in_ch.quat_x;
      wx_r <= in_ch.quat_w * in_ch.quat_x;
      yz_r <= in_ch.quat_y * in_ch.quat_z;
      xx_r <= in_ch.quat_x * in_ch.quat_x;
      yy_r <= in_ch.quat_y * in_ch.quat_y;
    end
  end

  // Stage 2: pitch sine half, roll numerator and denominator.
  assign sum_a = 33'(wx_r) + 33'(yz_r);
  assign sum_b = 33'(xx_r) + 33'(yy_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r     <= 33'(wy_r) - 33'(zx_r);
      num_d_r[0] <= 34'sd0 - (34'(sum_a) <<< 1);
      den_d_r[0] <= 34'sd268435456 - (34'(sum_b) <<< 1);
      for (int i = 1; i < SQ_W + 4; i++) begin
        num_d_r[i] <= num_d_r[i-1];
        den_d_r[i] <= den_d_r[i-1];
      end
    end
  end

  // Stage 3: sine saturated to +-1 and its magnitude.
  always_comb begin
    absd = (diff_r < 0) ? -diff_r : diff_r;
    if (diff_r > 33'sd134217728) begin
      s_nxt = (SQ_W+1)'(34'sd268435456);
    end else if (diff_r < -33'sd134217728) begin
      s_nxt = -(SQ_W+1)'(34'sd268435456);
    end else begin
      s_nxt = (SQ_W+1)'(diff_r <<< 1);
    end
    if (absd > 33'sd134217728) begin
      mag_nxt = SQ_W'(1) << 28;
    end else begin
      mag_nxt = SQ_W'(absd <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_d_r[0] <= s_nxt;
      mag_r    <= mag_nxt;
      for (int i = 1; i < SQ_W + 3; i++) s_d_r[i] <= s_d_r[i-1];
    end
  end

  // Stages 4 and 5: cosine squared as 2^56 - s^2.
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= SQ_IN_W'(mag_r) * SQ_IN_W'(mag_r);
      n_r  <= (SQ_IN_W'(1) << 56) - sq_r;
    end
  end

  ipr_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .n_in     (n_r),
    .root_out (root)
  );

  ipr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk   (clk),
    .en    (adv),
    .x_in  ($signed({{(CW-SQ_W){1'b0}}, root})),
    .y_in  (CW'(s_d_r[SQ_W+2])),
    .z_out (zp)
  );

  ipr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk   (clk),
    .en    (adv),
    .x_in  (CW'(den_d_r[SQ_W+3])),
    .y_in  (CW'(num_d_r[SQ_W+3])),
    .z_out (zr)
  );

  // Q20 to Q12 with rounding, then the symmetric clamp.
  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r <= RW'(((ZW+1)'(zp) + (ZW+1)'(128)) >>> 8);
      rr_r <= RW'(((ZW+1)'(zr) + (ZW+1)'(128)) >>> 8);
    end
  end

  assign lim_s = $signed(RW'(lim_r));
  assign pc = (pr_r > lim_s) ? lim_s : ((pr_r < -lim_s) ? -lim_s : pr_r);
  assign rc = (rr_r > lim_s) ? lim_s : ((rr_r < -lim_s) ? -lim_s : rr_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_r <= ANG_W'(pc);
      roll_r  <= ANG_W'(-rc);
    end
  end

  assign out_ch.valid         = vld_r[LAT-1];
  assign out_ch.timestamp_out = side_r[LAT-1].ts;
  assign out_ch.head_w        = side_r[LAT-1].hw;
  assign out_ch.head_x        = side_r[LAT-1].hx;
  assign out_ch.head_y        = side_r[LAT-1].hy;
  assign out_ch.head_z        = side_r[LAT-1].hz;
  assign out_ch.pitch_cmd     = pitch_r;
  assign out_ch.roll_cmd      = roll_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_bubble_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked although no result is waiting");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (lim_r == $past(cfg_wdata)))
    else $error("angle limit not updated by configuration write");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for imu_quat_to_clamped_pitch_roll: it predicts the remapped
// quaternion and the clamped pitch and roll of every transaction and compares them in order.
// Depends on ipr_pkg, the channel interfaces in ipr_if.sv and the block itself.
module tb;

  localparam int QW = ipr_pkg::QW;
  localparam int TS_W = ipr_pkg::TS_W;
  localparam int ANG_W = ipr_pkg::ANG_W;
  localparam int LIM_W = ipr_pkg::LIM_W;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = 60;
  localparam int ANG_STAGES = ipr_pkg::CORDIC_STAGES_DEF;
  localparam longint HALF_PI = 1647099;
  localparam longint ONE_Q28 = 64'sd1 << 28;

  typedef struct {
    logic [TS_W-1:0]         ts;
    logic signed [QW-1:0]    hw, hx, hy, hz;
    logic signed [ANG_W-1:0] pitch, roll;
  } head_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LIM_W-1:0] cfg_wdata;

  ipr_in_if in_ch();
  ipr_out_if out_ch();

  imu_quat_to_clamped_pitch_roll dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  head_cmd_t pending_cmds[$];
  logic [LIM_W-1:0] limit_now;
  int errors;
  int sent_count;
  int checked_count;
  int burst_left;
  int hold_cycles;
  int stall_mode;
  int stall_phase;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Vectoring arctangent in Q20 radians.
  function automatic longint vector_angle(longint yv, longint xv);
    longint ang, t, dx, dy;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = HALF_PI;
      end else begin
        xv = -yv; yv = t; ang = -HALF_PI;
      end
    end
    for (int i = 0; i < ANG_STAGES; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv += dx; yv -= dy; ang += ipr_pkg::atan_q20(5'(i));
      end else begin
        xv -= dx; yv += dy; ang -= ipr_pkg::atan_q20(5'(i));
      end
    end
    return ang;
  endfunction

  function automatic longint clamp_q12(longint a);
    longint r, lim;
    r = (a + 128) >>> 8;
    lim = longint'(limit_now);
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic signed [QW-1:0] flip_sat(longint v);
    longint n;
    n = -v;
    if (n > 32767) n = 32767;
    return n[QW-1:0];
  endfunction

  function automatic logic signed [ANG_W-1:0] r_neg(longint r);
    longint n;
    n = -r;
    return n[ANG_W-1:0];
  endfunction

  function automatic head_cmd_t predict_head(logic signed [QW-1:0] qw, logic signed [QW-1:0] qx,
                                             logic signed [QW-1:0] qy, logic signed [QW-1:0] qz,
                                             logic [TS_W-1:0] ts);
    head_cmd_t e;
    longint w, x, y, z, s, num, den, p, r;
    longint unsigned mag, c;
    w = qw; x = qx; y = qy; z = qz;
    s = 2 * (w * y - z * x);
    if (s > ONE_Q28) s = ONE_Q28;
    else if (s < -ONE_Q28) s = -ONE_Q28;
    mag = (s < 0) ? -s : s;
    c = int_sqrt((64'd1 << 56) - mag * mag);
    p = clamp_q12(vector_angle(s, longint'(c)));
    num = -2 * (w * x + y * z);
    den = ONE_Q28 - 2 * (x * x + y * y);
    r = clamp_q12(vector_angle(num, den));
    e.ts = ts;
    e.hw = qw;
    e.hx = flip_sat(x);
    e.hy = qy;
    e.hz = flip_sat(z);
    e.pitch = p[ANG_W-1:0];
    e.roll = r_neg(r);
    return e;
  endfunction

  // ---------------------------------------------------------------- result side

  // The receiver either holds off for a counted stretch or follows its own stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 250 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 9) < 7);
        2: out_ch.ready <= (stall_phase % 5 != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    head_cmd_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        $error("result transaction arrived with no expectation waiting");
        errors++;
      end else begin
        e = pending_cmds.pop_front();
        checked_count++;
        if (out_ch.timestamp_out !== e.ts) begin
          $error("timestamp_out: expected %0d, got %0d", e.ts, out_ch.timestamp_out);
          errors++;
        end
        if (out_ch.head_w !== e.hw) begin
          $error("head_w: expected %0d, got %0d", e.hw, out_ch.head_w);
          errors++;
        end
        if (out_ch.head_x !== e.hx) begin
          $error("head_x: expected %0d, got %0d", e.hx, out_ch.head_x);
          errors++;
        end
        if (out_ch.head_y !== e.hy) begin
          $error("head_y: expected %0d, got %0d", e.hy, out_ch.head_y);
          errors++;
        end
        if (out_ch.head_z !== e.hz) begin
          $error("head_z: expected %0d, got %0d", e.hz, out_ch.head_z);
          errors++;
        end
        if (out_ch.pitch_cmd !== e.pitch) begin
          $error("pitch_cmd: expected %0d, got %0d", e.pitch, out_ch.pitch_cmd);
          errors++;
        end
        if (out_ch.roll_cmd !== e.roll) begin
          $error("roll_cmd: expected %0d, got %0d", e.roll, out_ch.roll_cmd);
          errors++;
        end
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- input side

  task automatic send_quat(logic signed [QW-1:0] qw, logic signed [QW-1:0] qx,
                           logic signed [QW-1:0] qy, logic signed [QW-1:0] qz,
                           logic [TS_W-1:0] ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.quat_w <= qw;
    in_ch.quat_x <= qx;
    in_ch.quat_y <= qy;
    in_ch.quat_z <= qz;
    in_ch.timestamp_us <= ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_cmds.push_back(predict_head(qw, qx, qy, qz, ts));
    sent_count++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_now = v;
  endtask

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[TS_W-1:0];
  endfunction

  // Mostly unit quaternions; some arbitrary values in range and some across all 16 bits.
  task automatic send_random();
    real a, b, c, d, n;
    int kind;
    logic signed [QW-1:0] q[4];
    kind = $urandom_range(0, 19);
    if (kind < 15) begin
      a = $urandom_range(0, 20000) - 10000.0;
      b = $urandom_range(0, 20000) - 10000.0;
      c = $urandom_range(0, 20000) - 10000.0;
      d = $urandom_range(0, 20000) - 10000.0;
      if ($urandom_range(0, 3) == 0) c = c / 50.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) begin
        a = 1.0; n = 1.0;
      end
      q[0] = QW'($rtoi(a / n * 16384.0));
      q[1] = QW'($rtoi(b / n * 16384.0));
      q[2] = QW'($rtoi(c / n * 16384.0));
      q[3] = QW'($rtoi(d / n * 16384.0));
    end else if (kind < 18) begin
      foreach (q[i]) q[i] = QW'($urandom_range(0, 32768) - 16384);
    end else begin
      foreach (q[i]) q[i] = QW'($urandom);
    end
    send_quat(q[0], q[1], q[2], q[3], rand_ts());
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_special_values();
    send_quat(16384, 0, 0, 0, '0);
    send_quat(-16384, 0, 0, 0, '1);
    send_quat(0, 16384, 0, 0, 63'd1);
    send_quat(0, 0, 16384, 0, 63'd2);
    send_quat(0, 0, 0, 16384, 63'd3);
    send_quat(0, 0, -16384, 0, 63'd4);
    send_quat(0, 0, 0, 0, 63'h2AAA_AAAA_AAAA_AAAA);
    send_quat(0, 8192, 8192, 0, 63'h5555_5555_5555_5555);   // roll of the zero vector
    send_quat(11585, -32768, 0, -32768, 63'd5);              // saturating negation
    send_quat(32767, 32767, 32767, 32767, 63'd6);
    send_quat(-32768, -32768, -32768, -32768, 63'd7);
    send_quat(16384, 0, 16384, 0, 63'd8);                    // sine beyond +1
    send_quat(16384, 0, -16384, 0, 63'd9);                   // sine beyond -1
    send_quat(11585, 0, 11585, 0, 63'd10);
    send_quat(11585, 11585, 0, 0, 63'd11);
    send_quat(11585, -11585, 0, 0, 63'd12);
    send_quat(8192, 8192, 8192, 8192, 63'd13);
    send_quat(-1, 1, -1, 1, 63'd14);
  endtask

  task automatic test_limit_sweep();
    logic [LIM_W-1:0] limits[6];
    limits = '{13'd0, 13'd6434, 13'd8191, 13'd1, 13'd4915, 13'd0};
    limits[5] = LIM_W'($urandom_range(1, 6433));
    foreach (limits[k]) begin
      write_limit(limits[k]);
      send_quat(16384, 0, 16384, 0, rand_ts());
      send_quat(0, 16384, 0, 0, rand_ts());
      repeat (70) send_random();
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 400;
    repeat (150) send_random();
  endtask

  task automatic test_pause_and_resume();
    repeat (30) send_random();
    wait_drained();
    repeat (30) send_random();
  endtask

  task automatic test_random_attitudes();
    write_limit(LIM_W'($urandom_range(3000, 6434)));
    repeat (600) send_random();
    write_limit(ipr_pkg::LIMIT_RST);
    repeat (600) send_random();
  endtask

  initial begin
    errors = 0;
    sent_count = 0;
    checked_count = 0;
    burst_left = 0;
    hold_cycles = 0;
    stall_mode = 0;
    stall_phase = 0;
    idle_cycles = 0;
    limit_now = ipr_pkg::LIMIT_RST;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    in_ch.timestamp_us = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_values();
    test_limit_sweep();
    test_backpressure();
    test_pause_and_resume();
    test_random_attitudes();
    wait_drained();

    $display("Sent %0d quaternions and checked %0d results across several angle limits,",
             sent_count, checked_count);
    $display("with input gaps, output stalls and a long output hold-off.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ipr_pkg.sv
sv/ipr_if.sv
sv/ipr_isqrt.sv
sv/ipr_cordic.sv
sv/imu_quat_to_clamped_pitch_roll.sv
test/tb.sv
